/* design/swlh_pkg.sv */
// Shared types and constants for the switch edge lockout and homing block.
package swlh_pkg;

    localparam int SWITCH_COUNT = 3;

    localparam int LOCKOUT_W = 8;
    localparam int HOMING_W  = 16;
    localparam int CFG_DATA_W = HOMING_W;

    // Switch bit positions
    localparam int BIT_SW3 = 1;
    localparam int BIT_SW4 = 2;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_TICKS_RESET = LOCKOUT_W'(20);
    localparam logic [HOMING_W-1:0]  HOMING_LIMIT_RESET  = HOMING_W'(2000);

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_HOMING = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_GO   = 2'd1,
        CMD_STOP = 2'd2
    } cmd_t;

    typedef enum logic {
        REG_LOCKOUT_TICKS = 1'b0,
        REG_HOMING_LIMIT  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        cmd_t                    arm;
        cmd_t                    barrier;
        cmd_t                    rod;
        logic                    rod_zeroed;
        logic                    arm_homed;
        logic [SWITCH_COUNT-1:0] edge_flags;
        logic [SWITCH_COUNT-1:0] lockout;
    } result_t;

endpackage

/* design/switch_edge_lockout_homing.sv */
// Top level: limit switch edge qualification with lockout and timed homing.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | in        | in_valid / in_ready    | mode, switch_levels
//  out     | out       | out_valid / out_ready  | arm/barrier/rod_command, rod_zeroed,
//          |           |                        | arm_homed, edge_flags_out, lockout_out
//  cfg     | in        | cfg_write_en           | cfg_index, cfg_data
//
// State and the result register update at the accepting edge.
// The result register is the only stage; a new item is taken whenever it is empty or being
// drained in the same cycle, so one item per cycle is sustained while out_ready stays high.
// Reset sets the previous switch levels high, clears the flags, timers and homing state
// and loads the register defaults.
// A stall on the output holds the result and lowers in_ready until it is taken.
module switch_edge_lockout_homing (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          mode,
    input  logic [swlh_pkg::SWITCH_COUNT-1:0]   switch_levels,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          arm_command,
    output logic [1:0]                          barrier_command,
    output logic [1:0]                          rod_command,
    output logic                                rod_zeroed,
    output logic                                arm_homed,
    output logic [swlh_pkg::SWITCH_COUNT-1:0]   edge_flags_out,
    output logic [swlh_pkg::SWITCH_COUNT-1:0]   lockout_out,
    input  logic                                cfg_write_en,
    input  logic                                cfg_index,
    input  logic [swlh_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int N = swlh_pkg::SWITCH_COUNT;

    logic [swlh_pkg::LOCKOUT_W-1:0] lockout_ticks_reg;
    logic [swlh_pkg::HOMING_W-1:0]  homing_limit_reg;

    logic [N-1:0]                   prev_levels_reg, prev_levels_next;
    logic [N-1:0]                   edge_flags_reg, edge_flags_next;
    logic [N-1:0]                   lockout_reg, lockout_next;
    logic [swlh_pkg::LOCKOUT_W-1:0] timer_reg [N];
    logic [swlh_pkg::LOCKOUT_W-1:0] timer_next [N];
    logic                           running_reg, running_next;
    logic [swlh_pkg::HOMING_W-1:0]  elapsed_reg, elapsed_next;
    logic                           homed_reg, homed_next;

    logic                           out_valid_reg;
    swlh_pkg::result_t              result_reg, result_next;

    logic                           in_fire;
    logic [N-1:0]                   falls;
    logic [swlh_pkg::LOCKOUT_W-1:0] timer_inc [N];

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign falls    = ~switch_levels & prev_levels_reg & ~lockout_reg;

    always_comb
    begin
        prev_levels_next = prev_levels_reg;
        edge_flags_next  = edge_flags_reg;
        lockout_next     = lockout_reg;
        running_next     = running_reg;
        elapsed_next     = elapsed_reg;
        homed_next       = homed_reg;
        for (int i = 0; i < N; i++) begin
            timer_next[i] = timer_reg[i];
            timer_inc[i]  = timer_reg[i] + swlh_pkg::LOCKOUT_W'(1);
        end
        result_next.arm        = swlh_pkg::CMD_NONE;
        result_next.barrier    = swlh_pkg::CMD_NONE;
        result_next.rod        = swlh_pkg::CMD_NONE;
        result_next.rod_zeroed = 1'b0;

        case (swlh_pkg::mode_t'(mode))
            swlh_pkg::MODE_SAMPLE:
            begin
                edge_flags_next  = edge_flags_reg | falls;
                lockout_next     = lockout_reg | falls;
                prev_levels_next = switch_levels;
                for (int i = 0; i < N; i++) begin
                    if (falls[i]) begin
                        timer_next[i] = '0;
                    end
                end
            end
            swlh_pkg::MODE_TICK:
            begin
                if (running_reg) begin
                    elapsed_next = elapsed_reg + swlh_pkg::HOMING_W'(1);
                end
                for (int i = 0; i < N; i++) begin
                    if (lockout_reg[i]) begin
                        if (timer_inc[i] >= lockout_ticks_reg) begin
                            lockout_next[i] = 1'b0;
                            timer_next[i]   = '0;
                        end else begin
                            timer_next[i] = timer_inc[i];
                        end
                    end
                end
            end
            swlh_pkg::MODE_HOMING:
            begin
                running_next = 1'b1;
                if (elapsed_reg < homing_limit_reg) begin
                    result_next.arm     = swlh_pkg::CMD_GO;
                    result_next.barrier = swlh_pkg::CMD_GO;
                    // SW3 is only looked at once SW4 has stopped the barrier
                    if (edge_flags_reg[swlh_pkg::BIT_SW4]) begin
                        result_next.barrier = swlh_pkg::CMD_STOP;
                        result_next.rod     = swlh_pkg::CMD_GO;
                        edge_flags_next[swlh_pkg::BIT_SW4] = 1'b0;
                        if (edge_flags_reg[swlh_pkg::BIT_SW3]) begin
                            result_next.rod        = swlh_pkg::CMD_STOP;
                            result_next.rod_zeroed = 1'b1;
                            edge_flags_next[swlh_pkg::BIT_SW3] = 1'b0;
                        end
                    end
                end else begin
                    result_next.arm     = swlh_pkg::CMD_STOP;
                    result_next.barrier = swlh_pkg::CMD_STOP;
                    result_next.rod     = swlh_pkg::CMD_STOP;
                    edge_flags_next     = '0;
                    elapsed_next        = '0;
                    running_next        = 1'b0;
                    homed_next          = 1'b1;
                end
            end
            default:
            begin
                // unused mode: no state change
            end
        endcase

        result_next.arm_homed  = homed_next;
        result_next.edge_flags = edge_flags_next;
        result_next.lockout    = lockout_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lockout_ticks_reg <= swlh_pkg::LOCKOUT_TICKS_RESET;
            homing_limit_reg  <= swlh_pkg::HOMING_LIMIT_RESET;
            prev_levels_reg   <= '1;
            edge_flags_reg    <= '0;
            lockout_reg       <= '0;
            for (int i = 0; i < N; i++) begin
                timer_reg[i] <= '0;
            end
            running_reg       <= 1'b0;
            elapsed_reg       <= '0;
            homed_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_write_en) begin
                case (swlh_pkg::cfg_reg_t'(cfg_index))
                    swlh_pkg::REG_LOCKOUT_TICKS:
                        lockout_ticks_reg <= cfg_data[swlh_pkg::LOCKOUT_W-1:0];
                    swlh_pkg::REG_HOMING_LIMIT:
                        homing_limit_reg  <= cfg_data[swlh_pkg::HOMING_W-1:0];
                    default:
                        homing_limit_reg  <= homing_limit_reg;
                endcase
            end
            if (in_fire) begin
                prev_levels_reg <= prev_levels_next;
                edge_flags_reg  <= edge_flags_next;
                lockout_reg     <= lockout_next;
                for (int i = 0; i < N; i++) begin
                    timer_reg[i] <= timer_next[i];
                end
                running_reg     <= running_next;
                elapsed_reg     <= elapsed_next;
                homed_reg       <= homed_next;
                out_valid_reg   <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on every transfer in, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign arm_command     = result_reg.arm;
    assign barrier_command = result_reg.barrier;
    assign rod_command     = result_reg.rod;
    assign rod_zeroed      = result_reg.rod_zeroed;
    assign arm_homed       = result_reg.arm_homed;
    assign edge_flags_out  = result_reg.edge_flags;
    assign lockout_out     = result_reg.lockout;

`ifndef SYNTHESIS
    a_zeroed_with_rod_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.rod_zeroed |-> result_reg.rod == swlh_pkg::CMD_STOP)
        else $error("rod_zeroed without rod stop");

    a_timeout_clears_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.arm == swlh_pkg::CMD_STOP
        |-> result_reg.edge_flags == '0 && result_reg.arm_homed)
        else $error("homing timeout left flags set or homed clear");

    a_flags_rise_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (edge_flags_reg & ~$past(edge_flags_reg)) != '0
        |-> $past(in_fire) && $past(mode) == swlh_pkg::MODE_SAMPLE)
        else $error("edge flag set outside a sample transfer");

    a_homed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(homed_reg))
        else $error("homed flag cleared");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");
`endif

endmodule
